/* rtl/ows_pkg.sv */
`default_nettype none

package ows_pkg;

  // ROM geometry
  localparam int ROM_BYTES    = 8;
  localparam int TOTAL_BITS   = ROM_BYTES * 8;
  localparam int ROM_W        = 64;
  localparam int ROM_IDX_W    = 6;
  localparam int POS_W        = 7;
  localparam int GAP_W        = 4;
  localparam int FAMILY_LIMIT = 9;
  localparam int FAMILY_W     = 8;

  // Request queue between front and back
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // Request opcodes on the bus side
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_BIT   = 2'd2;

  typedef enum logic [1:0] {
    EVT_CLEAR,
    EVT_START,
    EVT_BIT,
    EVT_NOP
  } evt_kind_t;

  // Class of one id bit / complement bit pair
  typedef enum logic [1:0] {
    PAIR_ZERO,   // all devices show 0
    PAIR_ONE,    // all devices show 1
    PAIR_SPLIT,  // devices disagree
    PAIR_ABORT   // nobody answered
  } pair_t;

  typedef struct packed {
    evt_kind_t kind;
    logic      presence;
    pair_t     pair;
  } evt_t;

endpackage

`default_nettype wire

/* rtl/ows_if.sv */
`default_nettype none

interface ows_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic       presence;
  logic       id_bit;
  logic       complement_bit;

  modport source (output valid, opcode, presence, id_bit, complement_bit, input ready);
  modport sink   (input valid, opcode, presence, id_bit, complement_bit, output ready);
endinterface

interface ows_res_if;
  logic        valid;
  logic        ready;
  logic        direction;
  logic        needs_bus;
  logic        pass_done;
  logic        found;
  logic        last_device;
  logic [3:0]  family_discrepancy;
  logic [63:0] rom_id;

  modport source (output valid, direction, needs_bus, pass_done, found, last_device,
                  family_discrepancy, rom_id, input ready);
  modport sink   (input valid, direction, needs_bus, pass_done, found, last_device,
                  family_discrepancy, rom_id, output ready);
endinterface

`default_nettype wire

/* rtl/ows_front.sv */
`default_nettype none

module ows_front (
  ows_cmd_if.sink      cmd,
  input  wire logic    full,
  output logic         push,
  output ows_pkg::evt_t push_data
);
  import ows_pkg::*;

  assign cmd.ready = !full;
  assign push      = cmd.valid && !full;

  always_comb begin
    push_data.presence = cmd.presence;
    case (cmd.opcode)
      OP_CLEAR: push_data.kind = EVT_CLEAR;
      OP_START: push_data.kind = EVT_START;
      OP_BIT:   push_data.kind = EVT_BIT;
      default:  push_data.kind = EVT_NOP;
    endcase
    case ({cmd.id_bit, cmd.complement_bit})
      2'b00:   push_data.pair = PAIR_SPLIT;
      2'b01:   push_data.pair = PAIR_ZERO;
      2'b10:   push_data.pair = PAIR_ONE;
      default: push_data.pair = PAIR_ABORT;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/ows_queue.sv */
`default_nettype none

module ows_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire ows_pkg::evt_t push_data,
  output logic               full,
  input  wire logic          pop,
  output ows_pkg::evt_t      pop_data,
  output logic               empty
);
  import ows_pkg::*;

  evt_t              entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full     = (count == QCNT_W'(QDEPTH));
  assign empty    = (count == '0);
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/ows_back.sv */
`default_nettype none

module ows_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          empty,
  input  wire ows_pkg::evt_t evt,
  output logic               pop,
  ows_res_if.source          res
);
  import ows_pkg::*;

  logic [ROM_W-1:0] rom_code, rom_code_next;
  logic [POS_W-1:0] last_disc, last_disc_next;
  logic [GAP_W-1:0] family_gap, family_gap_next;
  logic             last_dev, last_dev_next;
  logic [POS_W-1:0] bit_pos, bit_pos_next;
  logic [POS_W-1:0] zero_pos, zero_pos_next;
  logic             active, active_next;

  logic             res_valid;
  logic             dir, needs, done, found;
  logic [ROM_IDX_W-1:0] idx;
  logic [POS_W-1:0] pos_inc;

  assign pop     = !empty && (!res_valid || res.ready);
  assign idx     = ROM_IDX_W'(bit_pos - 1'b1);
  assign pos_inc = bit_pos + 1'b1;

  always_comb begin
    rom_code_next   = rom_code;
    last_disc_next  = last_disc;
    family_gap_next = family_gap;
    last_dev_next   = last_dev;
    bit_pos_next    = bit_pos;
    zero_pos_next   = zero_pos;
    active_next     = active;
    dir   = 1'b0;
    needs = 1'b0;
    done  = 1'b0;
    found = 1'b0;
    if (pop) begin
      case (evt.kind)
        EVT_CLEAR: begin
          rom_code_next   = '0;
          last_disc_next  = '0;
          family_gap_next = '0;
          last_dev_next   = 1'b0;
          active_next     = 1'b0;
          bit_pos_next    = POS_W'(1);
          zero_pos_next   = '0;
        end
        EVT_START: begin
          bit_pos_next  = POS_W'(1);
          zero_pos_next = '0;
          active_next   = 1'b0;
          if (last_dev || !evt.presence) begin
            last_disc_next  = '0;
            family_gap_next = '0;
            last_dev_next   = 1'b0;
            done            = 1'b1;
          end else begin
            active_next = 1'b1;
            needs       = 1'b1;
          end
        end
        EVT_BIT: begin
          if (active) begin
            if (evt.pair == PAIR_ABORT) begin
              active_next     = 1'b0;
              last_disc_next  = '0;
              family_gap_next = '0;
              last_dev_next   = 1'b0;
              done            = 1'b1;
            end else begin
              case (evt.pair)
                PAIR_ONE:   dir = 1'b1;
                PAIR_SPLIT: dir = (bit_pos < last_disc) ? rom_code[idx]
                                                        : (bit_pos == last_disc);
                default:    dir = 1'b0;
              endcase
              // Remember where the path last took the zero branch
              if (evt.pair == PAIR_SPLIT && !dir) begin
                zero_pos_next = bit_pos;
                if (bit_pos < POS_W'(FAMILY_LIMIT)) begin
                  family_gap_next = GAP_W'(bit_pos);
                end
              end
              rom_code_next[idx] = dir;
              bit_pos_next       = pos_inc;
              if (pos_inc > POS_W'(TOTAL_BITS)) begin
                active_next    = 1'b0;
                done           = 1'b1;
                last_disc_next = zero_pos_next;
                if (zero_pos_next == '0) begin
                  last_dev_next = 1'b1;
                end
                // A zero family byte means a bogus device: drop the search
                if (rom_code_next[FAMILY_W-1:0] == '0) begin
                  last_disc_next  = '0;
                  family_gap_next = '0;
                  last_dev_next   = 1'b0;
                end else begin
                  found = 1'b1;
                end
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rom_code   <= '0;
      last_disc  <= '0;
      family_gap <= '0;
      last_dev   <= 1'b0;
      bit_pos    <= POS_W'(1);
      zero_pos   <= '0;
      active     <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      rom_code   <= rom_code_next;
      last_disc  <= last_disc_next;
      family_gap <= family_gap_next;
      last_dev   <= last_dev_next;
      bit_pos    <= bit_pos_next;
      zero_pos   <= zero_pos_next;
      active     <= active_next;
      if (pop) begin
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Result payload register
  always_ff @(posedge clk) begin
    if (pop) begin
      res.direction          <= dir;
      res.needs_bus          <= needs;
      res.pass_done          <= done;
      res.found              <= found;
      res.last_device        <= last_dev_next;
      res.family_discrepancy <= family_gap_next;
      res.rom_id             <= rom_code_next;
    end
  end

  assign res.valid = res_valid;

endmodule

`default_nettype wire

/* rtl/one_wire_rom_search.sv */
`default_nettype none

// 1-Wire ROM search engine. Each request on cmd is one event of the search:
// a clear of the search state, the start of a pass carrying the presence bit
// seen after the bus reset, or one id bit with its complement read from the
// bus. Every request yields exactly one response on res, in order, carrying
// the direction bit to write back, needs_bus on a successful start, a
// pass_done mark with found, the last-device flag, the last discrepancy
// inside the family byte and the ROM code built so far (bit 0 is the first
// bit on the bus). Issuing the 0xF0 search command, bus timing and the CRC
// check belong to the caller. A pass that reads 1 on both bits aborts, and a
// completed pass with a zero family byte counts as failed; either way the
// search restarts from scratch on the next pass. Throughput is one request
// per clock while res is not stalled: the front stage classifies a request
// and writes it into a two-entry queue, the back stage executes one queued
// request per cycle and loads the response register; each request passes
// the queue and that register; both sides may stall independently of each other.

module one_wire_rom_search (
  input  wire logic clk,
  input  wire logic rst,
  ows_cmd_if.sink   cmd,
  ows_res_if.source res
);
  import ows_pkg::*;

  logic push;
  logic pop;
  logic full;
  logic empty;
  evt_t push_data;
  evt_t pop_data;

  // Decode the request and hold it in the queue
  ows_front u_front (
    .cmd       (cmd),
    .full      (full),
    .push      (push),
    .push_data (push_data)
  );

  ows_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  // Advance the search state and register the response
  ows_back u_back (
    .clk   (clk),
    .rst   (rst),
    .empty (empty),
    .evt   (pop_data),
    .pop   (pop),
    .res   (res)
  );

endmodule

`default_nettype wire
